[hdl/wdcs_pkg.sv]
package wdcs_pkg;

  // Field widths fixed by the register map and the item formats.
  localparam int LOAD_W     = 29;
  localparam int ACC_W      = 35;
  localparam int TPW_W      = 7;
  localparam int HLEN_W     = 4;
  localparam int POLICY_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  typedef logic [LOAD_W-1:0] load_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICKS    = 3'd0,
    REG_HIST_LEN = 3'd1,
    REG_POLICY   = 3'd2,
    REG_UP       = 3'd3,
    REG_DOWN     = 3'd4
  } cfg_reg_t;

  // Demand policies.
  typedef enum logic [POLICY_W-1:0] {
    POL_RECENT        = 2'd0,
    POL_MAX           = 2'd1,
    POL_AVERAGE       = 2'd2,
    POL_AVG_OR_RECENT = 2'd3
  } policy_t;

  localparam logic [TPW_W-1:0]  TICKS_RST    = 7'd1;
  localparam logic [HLEN_W-1:0] HIST_LEN_RST = 4'd5;
  localparam policy_t           POLICY_RST   = POL_AVG_OR_RECENT;

endpackage

[hdl/wdcs_if.sv]
interface wdcs_in_if import wdcs_pkg::*; ();
  logic  valid;
  logic  ready;
  load_t peak_load;

  modport source (output valid, output peak_load, input ready);
  modport sink   (input valid, input peak_load, output ready);
endinterface

interface wdcs_out_if import wdcs_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  window_done;
  load_t demand;
  logic  big_active;

  modport source (output valid, output window_done, output demand, output big_active,
                  input ready);
  modport sink   (input valid, input window_done, input demand, input big_active,
                  output ready);
endinterface

interface wdcs_cfg_if import wdcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/windowed_demand_cluster_select.sv]
// Windowed demand estimator and big/little cluster selector.
//
// The sample channel takes one peak-load item per scheduler tick. The result
// channel returns exactly one item per sample: a window-done flag, the latest
// demand estimate and the cluster choice. The cfg channel writes the five
// registers and is always ready; the user must write it only while the block
// is idle, and the block itself does not enforce this.
// A tick that does not close an averaging window goes straight to the done
// step. A closing tick runs the tick division, the history shift and scan,
// the history division and the decision: a shared bit-serial restoring
// divider produces one quotient bit per cycle, first for the tick average
// and then, for the two policies that use it, for the history average; the
// history scan reads one entry a cycle. For the recent and max policies the
// second division is skipped. One sample is in work at a time.
//
// Reset clears the tick count, accumulator, history window and demand, and
// selects the big cluster. A finished result waits in the output register
// while the receiver stalls; the next sample is accepted meanwhile and its
// result is held in the last step until the output register frees up.
module windowed_demand_cluster_select
  import wdcs_pkg::*;
#(
  parameter int HIST_DEPTH = 8,
  parameter int MAX_TICKS  = 64
) (
  input logic        clk,
  input logic        rst,
  wdcs_in_if.sink    sample,
  wdcs_out_if.source result,
  wdcs_cfg_if.sink   cfg
);

  // History lengths reach HIST_DEPTH; the sum of the window needs room for it.
  localparam int LEN_W  = $clog2(HIST_DEPTH + 1);
  localparam int IDX_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SUM_W  = LOAD_W + LEN_W;
  localparam int DIV_W  = (ACC_W > SUM_W) ? ACC_W : SUM_W;
  localparam int CNT_W  = $clog2(DIV_W);
  // The register is only 7 bits wide, so the tick clamp never exceeds 127.
  localparam int TICK_CAP = (MAX_TICKS > 127) ? 127 : MAX_TICKS;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DIV_TICK = 7'b0000010,
    S_SHIFT    = 7'b0000100,
    S_SCAN     = 7'b0001000,
    S_DIV_LEN  = 7'b0010000,
    S_DECIDE   = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  // Configuration registers.
  logic [TPW_W-1:0]  ticks_per_window;
  logic [HLEN_W-1:0] history_length;
  policy_t           demand_policy;
  load_t             up_threshold;
  load_t             down_threshold;

  // Block state.
  state_t            state;
  logic [TPW_W-1:0]  tick_count;
  logic [ACC_W-1:0]  load_accumulator;
  load_t             history_window [HIST_DEPTH];
  load_t             last_demand;
  logic              big_selected;
  logic              window_hit;

  // Datapath registers.
  logic [DIV_W-1:0]  div_num;
  logic [TPW_W-1:0]  div_rem;
  logic [TPW_W-1:0]  div_den;
  logic [CNT_W-1:0]  div_cnt;
  load_t             window_avg;
  logic [SUM_W-1:0]  hist_sum;
  load_t             hist_top;
  logic [IDX_W-1:0]  scan_idx;

  // Output register.
  logic              out_valid;
  logic              out_done;
  load_t             out_demand;
  logic              out_big;
  logic              out_load;

  // Effective settings after clamping out-of-range register values.
  logic [TPW_W-1:0]  ticks_eff;
  logic [LEN_W-1:0]  len_eff;

  always_comb begin
    if (ticks_per_window == '0) begin
      ticks_eff = TPW_W'(1);
    end else if (int'(ticks_per_window) > TICK_CAP) begin
      ticks_eff = TPW_W'(TICK_CAP);
    end else begin
      ticks_eff = ticks_per_window;
    end
    if (history_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(history_length) > HIST_DEPTH) begin
      len_eff = LEN_W'(HIST_DEPTH);
    end else begin
      len_eff = LEN_W'(history_length);
    end
  end

  // Tick accumulation.
  logic [TPW_W-1:0] count_inc;
  logic [ACC_W-1:0] acc_sum;
  logic             sample_fire;

  assign sample.ready = (state == S_IDLE);
  assign sample_fire  = sample.valid && sample.ready;
  assign count_inc    = tick_count + TPW_W'(1);
  assign acc_sum      = load_accumulator + ACC_W'(sample.peak_load);

  // One restoring division step: a new quotient bit enters at the bottom of
  // the dividend register as the dividend bits leave at the top.
  logic [TPW_W:0]   div_trial;
  logic             div_fits;
  logic [TPW_W-1:0] div_rem_next;
  logic [DIV_W-1:0] div_num_next;
  logic             div_last;

  assign div_trial    = {div_rem, div_num[DIV_W-1]};
  assign div_fits     = (div_trial >= {1'b0, div_den});
  assign div_rem_next = div_fits ? TPW_W'(div_trial - {1'b0, div_den})
                                 : div_trial[TPW_W-1:0];
  assign div_num_next = {div_num[DIV_W-2:0], div_fits};
  assign div_last     = (div_cnt == CNT_W'(DIV_W - 1));

  // History scan: one entry per cycle for the running sum and maximum.
  load_t            scan_entry;
  logic [SUM_W-1:0] hist_sum_next;
  load_t            hist_top_next;
  logic             scan_last;
  logic             need_avg;

  assign scan_entry    = history_window[scan_idx];
  assign hist_sum_next = hist_sum + SUM_W'(scan_entry);
  assign hist_top_next = (scan_entry > hist_top) ? scan_entry : hist_top;
  assign scan_last     = (LEN_W'(scan_idx) == len_eff - LEN_W'(1));
  assign need_avg      = (demand_policy == POL_AVERAGE) ||
                         (demand_policy == POL_AVG_OR_RECENT);

  // Demand by policy. The history average never exceeds the window maximum,
  // so its low bits hold the whole quotient.
  load_t hist_avg;
  load_t demand_next;

  assign hist_avg = div_num[LOAD_W-1:0];

  always_comb begin
    case (demand_policy)
      POL_RECENT:  demand_next = window_avg;
      POL_MAX:     demand_next = hist_top;
      POL_AVERAGE: demand_next = hist_avg;
      default:     demand_next = (hist_avg > window_avg) ? hist_avg : window_avg;
    endcase
  end

  // The finished item moves into the output register once that is free or
  // is being read in the same cycle.
  assign out_load = (state == S_DONE) && (!out_valid || result.ready);

  // Configuration writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_window <= TICKS_RST;
      history_length   <= HIST_LEN_RST;
      demand_policy    <= POLICY_RST;
      up_threshold     <= '0;
      down_threshold   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TICKS:    ticks_per_window <= cfg.data[TPW_W-1:0];
        REG_HIST_LEN: history_length   <= cfg.data[HLEN_W-1:0];
        REG_POLICY:   demand_policy    <= policy_t'(cfg.data[POLICY_W-1:0]);
        REG_UP:       up_threshold     <= cfg.data[LOAD_W-1:0];
        REG_DOWN:     down_threshold   <= cfg.data[LOAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      tick_count       <= '0;
      load_accumulator <= '0;
      last_demand      <= '0;
      big_selected     <= 1'b1;
      window_hit       <= 1'b0;
      out_valid        <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        history_window[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_fire) begin
            if (count_inc >= ticks_eff) begin
              tick_count       <= '0;
              load_accumulator <= '0;
              window_hit       <= 1'b1;
              state            <= S_DIV_TICK;
            end else begin
              tick_count       <= count_inc;
              load_accumulator <= acc_sum;
              window_hit       <= 1'b0;
              state            <= S_DONE;
            end
          end
        end
        S_DIV_TICK: begin
          if (div_last) begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // Only the entries in use move; the rest keep their values.
          history_window[0] <= div_num[LOAD_W-1:0];
          for (int i = 1; i < HIST_DEPTH; i++) begin
            if (i < int'(len_eff)) begin
              history_window[i] <= history_window[i-1];
            end
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= need_avg ? S_DIV_LEN : S_DECIDE;
          end
        end
        S_DIV_LEN: begin
          if (div_last) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          last_demand <= demand_next;
          // The up test wins when the thresholds cross.
          if (demand_next > up_threshold) begin
            big_selected <= 1'b1;
          end else if (demand_next < down_threshold) begin
            big_selected <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        div_num <= DIV_W'(acc_sum);
        div_rem <= '0;
        div_den <= ticks_eff;
        div_cnt <= '0;
      end
      S_DIV_TICK, S_DIV_LEN: begin
        div_num <= div_num_next;
        div_rem <= div_rem_next;
        div_cnt <= div_cnt + CNT_W'(1);
      end
      S_SHIFT: begin
        window_avg <= div_num[LOAD_W-1:0];
        hist_sum   <= '0;
        hist_top   <= '0;
        scan_idx   <= '0;
      end
      S_SCAN: begin
        hist_sum <= hist_sum_next;
        hist_top <= hist_top_next;
        scan_idx <= scan_idx + IDX_W'(1);
        if (scan_last) begin
          div_num <= DIV_W'(hist_sum_next);
          div_rem <= '0;
          div_den <= TPW_W'(len_eff);
          div_cnt <= '0;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_done   <= window_hit;
          out_demand <= last_demand;
          out_big    <= big_selected;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid       = out_valid;
  assign result.window_done = out_done;
  assign result.demand      = out_demand;
  assign result.big_active  = out_big;

endmodule

[sim/windowed_demand_cluster_select_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the windowed demand estimator. Samples go in on one
// channel, and every sample produces exactly one result item. A predictor in
// this module keeps its own copy of the tick count, accumulator, history
// window and cluster choice. For each accepted sample it queues the item that
// the block must return. A checker on the result channel pops the oldest entry
// and compares it field by field.
module windowed_demand_cluster_select_tb;
  import wdcs_pkg::*;

  localparam int     HIST_DEPTH  = 8;
  localparam int     MAX_TICKS   = 64;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     IDLE_PCT    = 37;
  localparam load_t  FULL_LOAD   = '1;

  // One result item as the block presents it.
  typedef struct packed {
    logic  window_done;
    load_t demand;
    logic  big_active;
  } choice_t;

  logic clk = 1'b0;
  logic rst;

  wdcs_in_if  sample_bus ();
  wdcs_out_if result_bus ();
  wdcs_cfg_if cfg_bus ();

  windowed_demand_cluster_select #(
    .HIST_DEPTH(HIST_DEPTH),
    .MAX_TICKS (MAX_TICKS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .sample(sample_bus),
    .result(result_bus),
    .cfg   (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the register file, starting at the reset values.
  logic [TPW_W-1:0]  set_ticks    = TICKS_RST;
  logic [HLEN_W-1:0] set_hist_len = HIST_LEN_RST;
  policy_t           set_policy   = POLICY_RST;
  load_t             set_up       = '0;
  load_t             set_down     = '0;

  // Predictor copy of the block state. Slot 0 of the history is the newest.
  logic [TPW_W-1:0]  win_ticks   = '0;
  logic [ACC_W-1:0]  load_sum    = '0;
  load_t             hist [HIST_DEPTH] = '{default: '0};
  load_t             held_demand = '0;
  logic              big_now     = 1'b1;

  // Result items still owed by the block, oldest first.
  choice_t expected_choices[$];

  bit sample_idle_en = 1'b1;
  bit result_idle_en = 1'b1;
  int error_count    = 0;
  int samples_sent   = 0;
  int results_seen   = 0;
  int windows_seen   = 0;
  int cluster_swaps  = 0;
  int phases_run     = 0;
  int cycle_count    = 0;
  logic last_big     = 1'b1;

  // Every mismatch goes through here. Printing stops after a while so that a
  // badly broken block cannot flood the log, but the count keeps going.
  task automatic report_mismatch(input string what, input load_t got, input load_t want);
    if (error_count < 40) begin
      $display("MISMATCH %s: got %0d, expected %0d (result %0d, cycle %0d)",
               what, got, want, results_seen, cycle_count);
    end
    error_count++;
  endtask

  // Work out the result item for one accepted sample and queue it. The
  // window length and the history length are clamped into their legal
  // ranges, a window closes as soon as the count reaches or passes the
  // window length, and only the slots in use shift, so slots beyond the
  // current length keep their old values for a later, longer window.
  task automatic predict_cluster_choice(input load_t load);
    logic [TPW_W-1:0]  span;
    logic [HLEN_W-1:0] depth;
    logic [LOAD_W+3:0] hist_sum;
    load_t             avg;
    load_t             top;
    load_t             hist_avg;
    choice_t           want;
    span  = (set_ticks == 0) ? TPW_W'(1) :
            (set_ticks > MAX_TICKS) ? TPW_W'(MAX_TICKS) : set_ticks;
    depth = (set_hist_len == 0) ? HLEN_W'(1) :
            (set_hist_len > HIST_DEPTH) ? HLEN_W'(HIST_DEPTH) : set_hist_len;
    win_ticks = win_ticks + 1'b1;
    load_sum  = load_sum + load;
    want.window_done = 1'b0;
    if (win_ticks >= span) begin
      avg = load_t'(load_sum / span);
      win_ticks = '0;
      load_sum  = '0;
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        if (i < depth) hist[i] = hist[i-1];
      end
      hist[0] = avg;
      hist_sum = '0;
      top = '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        if (i < depth) begin
          hist_sum += hist[i];
          if (hist[i] > top) top = hist[i];
        end
      end
      hist_avg = load_t'(hist_sum / depth);
      case (set_policy)
        POL_RECENT:  held_demand = avg;
        POL_MAX:     held_demand = top;
        POL_AVERAGE: held_demand = hist_avg;
        default:     held_demand = (hist_avg > avg) ? hist_avg : avg;
      endcase
      // The up test is made first, so it wins when the thresholds cross.
      if (held_demand > set_up) begin
        big_now = 1'b1;
      end else if (held_demand < set_down) begin
        big_now = 1'b0;
      end
      want.window_done = 1'b1;
    end
    want.demand     = held_demand;
    want.big_active = big_now;
    expected_choices.push_back(want);
  endtask

  // Offer one sample. The task starts just after a rising edge and returns
  // just after the edge that accepted the item. Valid is left high, so the
  // next sample can follow with no gap; whoever stops sending lowers it.
  task automatic send_sample(input load_t load);
    @(negedge clk);
    while (sample_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      sample_bus.valid <= 1'b0;
      @(negedge clk);
    end
    sample_bus.valid     <= 1'b1;
    sample_bus.peak_load <= load;
    do @(posedge clk); while (sample_bus.ready !== 1'b1);
    predict_cluster_choice(load);
    samples_sent++;
  endtask

  // Stop sending and wait until every queued result item has come back.
  // Each sample yields a result, so an empty queue means the block is idle.
  task automatic wait_for_results();
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    while (expected_choices.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register and mirror it into the predictor. Callers make sure
  // the block is idle first.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_TICKS:    set_ticks    = value[TPW_W-1:0];
      REG_HIST_LEN: set_hist_len = value[HLEN_W-1:0];
      REG_POLICY:   set_policy   = policy_t'(value[POLICY_W-1:0]);
      REG_UP:       set_up       = value;
      REG_DOWN:     set_down     = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Reset values: one tick per window, five history slots, the larger of
  // average and newest, and both thresholds at zero. A zero demand then
  // neither rises above nor falls below, so the big cluster holds.
  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(FULL_LOAD);
    send_sample(load_t'(1000));
  endtask

  // Every demand policy over a short history that already holds data.
  task automatic test_each_policy();
    policy_t all_pols[4] = '{POL_RECENT, POL_MAX, POL_AVERAGE, POL_AVG_OR_RECENT};
    wait_for_results();
    write_reg(REG_HIST_LEN, CFG_DATA_W'(4));
    foreach (all_pols[k]) begin
      wait_for_results();
      write_reg(REG_POLICY, CFG_DATA_W'(all_pols[k]));
      send_sample(load_t'($urandom()));
      send_sample(load_t'($urandom_range(0, 1000)));
    end
  endtask

  // A window length of zero acts as one. Two full-scale samples over a
  // two-tick window give a full-scale average.
  task automatic test_window_clamps();
    wait_for_results();
    write_reg(REG_TICKS, '0);
    send_sample(load_t'(12345));
    wait_for_results();
    write_reg(REG_TICKS, CFG_DATA_W'(2));
    send_sample(FULL_LOAD);
    send_sample(FULL_LOAD);
  endtask

  // History lengths of zero and above the depth clamp to one and to eight.
  task automatic test_history_clamps();
    wait_for_results();
    write_reg(REG_TICKS, CFG_DATA_W'(1));
    write_reg(REG_HIST_LEN, '0);
    send_sample(load_t'(777));
    wait_for_results();
    write_reg(REG_HIST_LEN, CFG_DATA_W'(15));
    send_sample(load_t'(3));
  endtask

  // Two ticks into a three-tick window, the window is cut to one tick. The
  // next sample closes it at once; the sum of three near full-scale samples
  // divided by one is cut to the load width.
  task automatic test_window_lowered();
    wait_for_results();
    write_reg(REG_TICKS, CFG_DATA_W'(3));
    send_sample(FULL_LOAD);
    send_sample(FULL_LOAD - 1'b1);
    wait_for_results();
    write_reg(REG_TICKS, CFG_DATA_W'(1));
    send_sample(FULL_LOAD - 2'd2);
  endtask

  // Shrink the history and grow it again. Under the max policy, stale slots
  // beyond the short length show up again once the length is back at eight.
  task automatic test_stale_history();
    wait_for_results();
    write_reg(REG_POLICY, CFG_DATA_W'(POL_MAX));
    write_reg(REG_HIST_LEN, CFG_DATA_W'(3));
    send_sample(load_t'(40));
    send_sample(load_t'(20));
    send_sample(load_t'(30));
    wait_for_results();
    write_reg(REG_HIST_LEN, CFG_DATA_W'(1));
    send_sample(load_t'(5));
    wait_for_results();
    write_reg(REG_HIST_LEN, CFG_DATA_W'(8));
    send_sample(load_t'(1));
  endtask

  // Threshold corners with demand equal to the newest sample: crossed
  // thresholds, where the up test wins, and thresholds at full scale.
  task automatic test_threshold_edges();
    wait_for_results();
    write_reg(REG_POLICY, CFG_DATA_W'(POL_RECENT));
    write_reg(REG_UP, CFG_DATA_W'(100));
    write_reg(REG_DOWN, CFG_DATA_W'(1000));
    send_sample(load_t'(50));
    send_sample(load_t'(500));
    wait_for_results();
    write_reg(REG_UP, FULL_LOAD);
    write_reg(REG_DOWN, '0);
    send_sample(FULL_LOAD);
    wait_for_results();
    write_reg(REG_DOWN, FULL_LOAD);
    send_sample(load_t'(7));
  endtask

  // Random phases, each with its own register setting. Phase 1 runs without
  // any idling on either side; phases 2 and 5 use the longest windows with
  // extreme loads; every third phase drains the results halfway through.
  // Short registers sometimes get junk in the unused upper data bits.
  task automatic test_random_traffic(input int phases, input int per_phase);
    int                mode;
    logic [TPW_W-1:0]  ticks;
    logic [HLEN_W-1:0] hlen;
    load_t             lim;
    load_t             junk;
    load_t             load;
    for (int p = 0; p < phases; p++) begin
      wait_for_results();
      sample_idle_en = (p != 1);
      result_idle_en = (p != 1);
      mode = $urandom_range(0, 2);
      if (p == 2 || p == 5) mode = 2;
      lim = (mode == 1) ? load_t'(1000) : FULL_LOAD;
      if (p == 2) begin
        ticks = TPW_W'(127);
      end else if (p == 5) begin
        ticks = TPW_W'(MAX_TICKS);
      end else begin
        ticks = TPW_W'($urandom_range(0, 8));
      end
      hlen = HLEN_W'($urandom_range(0, 15));
      junk = ($urandom_range(0, 1) == 1) ? load_t'($urandom()) : '0;
      write_reg(REG_TICKS, {junk[LOAD_W-1:TPW_W], ticks});
      write_reg(REG_HIST_LEN, {junk[LOAD_W-1:HLEN_W], hlen});
      write_reg(REG_POLICY, {junk[LOAD_W-1:POLICY_W], POLICY_W'($urandom_range(0, 3))});
      write_reg(REG_UP, load_t'($urandom_range(0, lim)));
      write_reg(REG_DOWN, load_t'($urandom_range(0, lim)));
      for (int n = 0; n < per_phase; n++) begin
        // One sample in eight is full-range noise, whatever the phase.
        case (($urandom_range(0, 7) == 0) ? 0 : mode)
          0:       load = load_t'($urandom());
          1:       load = load_t'($urandom_range(0, 1000));
          default: load = ($urandom_range(0, 1) == 1) ? FULL_LOAD - load_t'($urandom_range(0, 3))
                                                      : load_t'($urandom_range(0, 15));
        endcase
        send_sample(load);
        if (p % 3 == 0 && n == per_phase / 2) wait_for_results();
      end
      phases_run++;
    end
  endtask

  // The receiver stalls at random, except while idling is switched off.
  always @(negedge clk) begin
    if (result_idle_en) begin
      result_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin : check_results
    choice_t want;
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (expected_choices.size() == 0) begin
        report_mismatch("result with no sample pending", result_bus.demand, '0);
      end else begin
        want = expected_choices.pop_front();
        if (result_bus.window_done !== want.window_done) begin
          report_mismatch("window_done", load_t'(result_bus.window_done),
                          load_t'(want.window_done));
        end
        if (result_bus.demand !== want.demand) begin
          report_mismatch("demand", result_bus.demand, want.demand);
        end
        if (result_bus.big_active !== want.big_active) begin
          report_mismatch("big_active", load_t'(result_bus.big_active),
                          load_t'(want.big_active));
        end
        if (want.window_done) windows_seen++;
        if (want.big_active != last_big) cluster_swaps++;
        last_big = want.big_active;
      end
      results_seen++;
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("windowed_demand_cluster_select_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst                  = 1'b1;
    sample_bus.valid     = 1'b0;
    sample_bus.peak_load = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = REG_TICKS;
    cfg_bus.data         = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_each_policy();
    test_window_clamps();
    test_history_clamps();
    test_window_lowered();
    test_stale_history();
    test_threshold_edges();
    test_random_traffic(8, 90);

    // Drain, then give a slow window computation time to show any stray item.
    wait_for_results();
    repeat (100) @(posedge clk);
    $display("Sent %0d samples and checked %0d results; %0d closed a window.",
             samples_sent, results_seen, windows_seen);
    $display("The cluster choice changed %0d times over %0d random settings.",
             cluster_swaps, phases_run);
    if (error_count == 0) begin
      $display("windowed_demand_cluster_select_tb: done, clean");
    end else begin
      $display("windowed_demand_cluster_select_tb: done, errors");
    end
    $finish;
  end

endmodule

[windowed_demand_cluster_select.f]
hdl/wdcs_pkg.sv
hdl/wdcs_if.sv
hdl/windowed_demand_cluster_select.sv
sim/windowed_demand_cluster_select_tb.sv
